/* rtl/core/sma_pkg.sv */
// Shared types and codes for the stack machine ALU.
// No dependencies.
package sma_pkg;
  localparam int CMD_W = 5;
  localparam int LIT_W = 32;
  localparam int TOP_W = 32;
  localparam int CNT_W = 7;
  localparam int FLT_W = 2;

  localparam logic [CMD_W-1:0] OP_PUSH = 5'd0;
  localparam logic [CMD_W-1:0] OP_DROP = 5'd1;
  localparam logic [CMD_W-1:0] OP_SWAP = 5'd2;
  localparam logic [CMD_W-1:0] OP_DUP  = 5'd3;
  localparam logic [CMD_W-1:0] OP_QDUP = 5'd4;
  localparam logic [CMD_W-1:0] OP_OVER = 5'd5;
  localparam logic [CMD_W-1:0] OP_ROT  = 5'd6;
  localparam logic [CMD_W-1:0] OP_NROT = 5'd7;
  localparam logic [CMD_W-1:0] OP_ADD  = 5'd8;
  localparam logic [CMD_W-1:0] OP_SUB  = 5'd9;
  localparam logic [CMD_W-1:0] OP_MUL  = 5'd10;
  localparam logic [CMD_W-1:0] OP_DIV  = 5'd11;
  localparam logic [CMD_W-1:0] OP_MOD  = 5'd12;
  localparam logic [CMD_W-1:0] OP_EQ   = 5'd13;
  localparam logic [CMD_W-1:0] OP_NE   = 5'd14;
  localparam logic [CMD_W-1:0] OP_LT   = 5'd15;
  localparam logic [CMD_W-1:0] OP_GT   = 5'd16;
  localparam logic [CMD_W-1:0] OP_LE   = 5'd17;
  localparam logic [CMD_W-1:0] OP_GE   = 5'd18;
  localparam logic [CMD_W-1:0] OP_AND  = 5'd19;
  localparam logic [CMD_W-1:0] OP_OR   = 5'd20;
  localparam logic [CMD_W-1:0] OP_XOR  = 5'd21;
  localparam logic [CMD_W-1:0] OP_NOT  = 5'd22;

  localparam logic [FLT_W-1:0] FLT_OK    = 2'd0;
  localparam logic [FLT_W-1:0] FLT_UNDER = 2'd1;
  localparam logic [FLT_W-1:0] FLT_OVER  = 2'd2;
  localparam logic [FLT_W-1:0] FLT_DIVZ  = 2'd3;

  // Request to and status from the shared arithmetic unit.
  typedef struct packed {
    logic             start;
    logic [CMD_W-1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;
endpackage

/* rtl/core/sma_if.sv */
// Valid/ready channels for operations in and results out.
// Depends on sma_pkg.
interface sma_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [sma_pkg::CMD_W-1:0]    cmd;
  logic signed [sma_pkg::LIT_W-1:0] literal;
  modport source (output valid, output cmd, output literal, input ready);
  modport sink (input valid, input cmd, input literal, output ready);
endinterface

interface sma_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [sma_pkg::TOP_W-1:0] top_value;
  logic [sma_pkg::CNT_W-1:0]        stack_count;
  logic [sma_pkg::FLT_W-1:0]        fault;
  modport source (output valid, output top_value, output stack_count, output fault,
                  input ready);
  modport sink (input valid, input top_value, input stack_count, input fault,
                output ready);
endinterface

/* rtl/core/sma_alu.sv */
// Shared arithmetic unit: registered add/compare/logic, bit-serial multiply and
// restoring divide. Depends on sma_pkg.
module sma_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sma_pkg::alu_req_t        req,
  input  logic [DATA_WIDTH-1:0]    lhs,
  input  logic [DATA_WIDTH-1:0]    rhs,
  output sma_pkg::alu_rsp_t        rsp,
  output logic [DATA_WIDTH-1:0]    result
);
  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam int CMD_OP_W = sma_pkg::CMD_W;

  logic                  busy;
  logic [CW-1:0]         count;
  logic [CMD_OP_W-1:0]   op_q;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvs;
  logic                  neg_q;
  logic                  neg_r;
  logic                  done;
  logic [DATA_WIDTH-1:0] simple;
  logic [DATA_WIDTH:0]   trial;
  logic signed [DATA_WIDTH-1:0] sl;
  logic signed [DATA_WIDTH-1:0] sr;
  logic [DATA_WIDTH-1:0] abs_l;
  logic [DATA_WIDTH-1:0] abs_r;
  logic [DATA_WIDTH-1:0] fin;
  logic                  long_op;
  logic [DATA_WIDTH-1:0] result_q_hold;

  assign sl = lhs;
  assign sr = rhs;
  assign abs_l = lhs[DATA_WIDTH-1] ? (~lhs + 1'b1) : lhs;
  assign abs_r = rhs[DATA_WIDTH-1] ? (~rhs + 1'b1) : rhs;
  assign trial = {acc, quo[DATA_WIDTH-1]} - {1'b0, dvs};

  always_comb begin
    simple = '0;
    case (req.op)
      sma_pkg::OP_ADD: simple = lhs + rhs;
      sma_pkg::OP_SUB: simple = lhs - rhs;
      sma_pkg::OP_EQ:  simple = DATA_WIDTH'(sl == sr);
      sma_pkg::OP_NE:  simple = DATA_WIDTH'(sl != sr);
      sma_pkg::OP_LT:  simple = DATA_WIDTH'(sl < sr);
      sma_pkg::OP_GT:  simple = DATA_WIDTH'(sl > sr);
      sma_pkg::OP_LE:  simple = DATA_WIDTH'(sl <= sr);
      sma_pkg::OP_GE:  simple = DATA_WIDTH'(sl >= sr);
      sma_pkg::OP_AND: simple = lhs & rhs;
      sma_pkg::OP_OR:  simple = lhs | rhs;
      sma_pkg::OP_XOR: simple = lhs ^ rhs;
      default:         simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
      op_q <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        op_q <= req.op;
        if (req.op == sma_pkg::OP_MUL || req.op == sma_pkg::OP_DIV ||
            req.op == sma_pkg::OP_MOD) begin
          busy <= 1'b1;
          count <= CW'(DATA_WIDTH);
        end else begin
          done <= 1'b1;
        end
        // multiply: acc = product, quo = multiplier, dvs = multiplicand
        if (req.op == sma_pkg::OP_MUL) begin
          acc <= '0;
          quo <= rhs;
          dvs <= lhs;
        end else begin
          acc <= '0;
          quo <= abs_l;
          dvs <= abs_r;
          neg_q <= lhs[DATA_WIDTH-1] ^ rhs[DATA_WIDTH-1];
          neg_r <= lhs[DATA_WIDTH-1];
        end
      end else if (busy) begin
        if (op_q == sma_pkg::OP_MUL) begin
          // add-shift: product wraps to cell width
          if (quo[0]) acc <= acc + dvs;
          quo <= quo >> 1;
          dvs <= dvs << 1;
        end else begin
          if (!trial[DATA_WIDTH]) begin
            acc <= trial[DATA_WIDTH-1:0];
            quo <= {quo[DATA_WIDTH-2:0], 1'b1};
          end else begin
            acc <= {acc[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
            quo <= {quo[DATA_WIDTH-2:0], 1'b0};
          end
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiply passes the product through; divide and modulo fold the sign here.
  always_comb begin
    if (op_q == sma_pkg::OP_MUL) fin = acc;
    else if (op_q == sma_pkg::OP_DIV) fin = neg_q ? (~quo + 1'b1) : quo;
    else fin = neg_r ? (~acc + 1'b1) : acc;
  end

  assign long_op = op_q == sma_pkg::OP_MUL || op_q == sma_pkg::OP_DIV ||
                   op_q == sma_pkg::OP_MOD;
  assign rsp.done = done;

  always_ff @(posedge clk) begin
    if (req.start && !busy && !(req.op == sma_pkg::OP_MUL ||
        req.op == sma_pkg::OP_DIV || req.op == sma_pkg::OP_MOD))
      result_q_hold <= simple;
  end

  assign result = long_op ? fin : result_q_hold;
endmodule

/* rtl/core/stack_machine_alu_unit.sv */
// Top level of the stack machine ALU: sequencer, stack memory, result register.
// Depends on sma_pkg, sma_if and sma_alu.
// Each operation reads the cells it needs one per cycle from the single-port stack
// memory and writes the changed cells back one per cycle. Add, subtract, compare,
// logic, multiply, divide and modulo go through the shared unit; multiply, divide
// and modulo wait for its bit-serial steps. A drop that leaves cells on the stack
// reads the new top back before the result. Faulting steps, ?dup of zero and unused
// codes write nothing. The block is ready again in the cycle after the result transfer.
module stack_machine_alu_unit #(
  parameter int DATA_WIDTH  = 32,
  parameter int STACK_DEPTH = 64
) (
  input logic      clk,
  input logic      rst,
  sma_cmd_if.sink  in_ch,
  sma_res_if.source out_ch
);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int CW  = sma_pkg::CMD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_ALU   = 4'd5;
  localparam logic [3:0] S_WR0   = 4'd6;
  localparam logic [3:0] S_WR1   = 4'd7;
  localparam logic [3:0] S_WR2   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_WAIT  = 4'd10;
  localparam logic [3:0] S_TOP0  = 4'd11;
  localparam logic [3:0] S_TOP1  = 4'd12;

  logic [3:0]            state;
  logic [CW-1:0]         cmd;
  logic [DATA_WIDTH-1:0] lit;
  logic [DW-1:0]         depth;
  logic [DATA_WIDTH-1:0] c0, c1, c2;   // top, second, third
  logic [DATA_WIDTH-1:0] w0, w1, w2;   // values to write at top, -1, -2
  logic [1:0]            nwr;
  logic [DW-1:0]         new_depth;
  logic [1:0]            fault;
  logic [DATA_WIDTH-1:0] top;

  logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         addr;
  logic                  we;
  logic [DATA_WIDTH-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd_data <= mem[addr];
  end

  sma_pkg::alu_req_t req;
  sma_pkg::alu_rsp_t rsp;
  logic [DATA_WIDTH-1:0] alu_res;
  logic                  alu_start;

  sma_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .clk(clk), .rst(rst), .req(req), .lhs(c1), .rhs(c0), .rsp(rsp), .result(alu_res)
  );

  logic [1:0] need;
  logic       grows;
  always_comb begin
    need = 2'd0;
    grows = 1'b0;
    unique case (cmd) inside
      sma_pkg::OP_PUSH: grows = 1'b1;
      sma_pkg::OP_DROP, sma_pkg::OP_NOT, sma_pkg::OP_QDUP: need = 2'd1;
      sma_pkg::OP_DUP: begin
        need = 2'd1;
        grows = 1'b1;
      end
      sma_pkg::OP_OVER: begin
        need = 2'd2;
        grows = 1'b1;
      end
      sma_pkg::OP_ROT, sma_pkg::OP_NROT: need = 2'd3;
      sma_pkg::OP_SWAP, [sma_pkg::OP_ADD:sma_pkg::OP_XOR]: need = 2'd2;
      default: need = 2'd0;
    endcase
  end

  logic full;
  assign full = depth == DW'(STACK_DEPTH);

  // cell address k below top of current depth
  function automatic logic [AW-1:0] slot(input logic [DW-1:0] d, input logic [1:0] k);
    logic [DW-1:0] t;
    t = d - DW'(k) - DW'(1);
    return t[AW-1:0];
  endfunction

  assign in_ch.ready = state == S_IDLE;
  assign req = '{start: alu_start, op: cmd};

  always_comb begin
    addr = slot(depth, 2'd0);
    we = 1'b0;
    wd = w0;
    unique case (state)
      S_RD0:  addr = slot(depth, 2'd0);
      S_RD1:  addr = slot(depth, 2'd1);
      S_RD2:  addr = slot(depth, 2'd2);
      S_WR0: begin
        // drop only moves the depth and writes nothing
        addr = slot(new_depth, 2'd0);
        we = nwr != 2'd0;
        wd = w0;
      end
      S_WR1: begin
        addr = slot(new_depth, 2'd1);
        we = 1'b1;
        wd = w1;
      end
      S_WR2: begin
        addr = slot(new_depth, 2'd2);
        we = 1'b1;
        wd = w2;
      end
      default: addr = slot(depth, 2'd0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
      out_ch.valid <= 1'b0;
      alu_start <= 1'b0;
    end else begin
      alu_start <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          cmd <= in_ch.cmd;
          lit <= DATA_WIDTH'(signed'(in_ch.literal));
          state <= S_RD0;
        end
        S_RD0: begin
          // first read in flight; decide how many more cells
          if (DW'(need) > depth) state <= S_EXEC;
          else if (need >= 2'd2) state <= S_RD1;
          else state <= S_EXEC;
        end
        S_RD1: begin
          c0 <= rd_data;
          state <= (need == 2'd3) ? S_RD2 : S_EXEC;
        end
        S_RD2: begin
          c1 <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          // collect the last read; on underflow only the top was read
          if (DW'(need) > depth || need <= 2'd1) c0 <= rd_data;
          else if (need == 2'd3) c2 <= rd_data;
          else c1 <= rd_data;
          state <= S_ALU;
        end
        S_ALU: begin
          fault <= sma_pkg::FLT_OK;
          new_depth <= depth;
          nwr <= 2'd0;
          top <= c0;
          state <= S_OUT;
          if (DW'(need) > depth) begin
            fault <= sma_pkg::FLT_UNDER;
          end else if (cmd == sma_pkg::OP_QDUP && c0 != '0) begin
            if (full) fault <= sma_pkg::FLT_OVER;
            else begin
              new_depth <= depth + 1'b1;
              w0 <= c0;
              nwr <= 2'd1;
              state <= S_WR0;
            end
          end else if (grows && full) begin
            fault <= sma_pkg::FLT_OVER;
          end else if ((cmd == sma_pkg::OP_DIV || cmd == sma_pkg::OP_MOD) &&
                       c0 == '0) begin
            fault <= sma_pkg::FLT_DIVZ;
          end else begin
            case (cmd)
              sma_pkg::OP_PUSH: begin
                new_depth <= depth + 1'b1; w0 <= lit; nwr <= 2'd1; state <= S_WR0;
              end
              sma_pkg::OP_DROP: begin
                new_depth <= depth - 1'b1; state <= S_WR0; nwr <= 2'd0;
              end
              sma_pkg::OP_SWAP: begin
                w0 <= c1; w1 <= c0; nwr <= 2'd2; state <= S_WR0;
              end
              sma_pkg::OP_DUP: begin
                new_depth <= depth + 1'b1; w0 <= c0; nwr <= 2'd1; state <= S_WR0;
              end
              sma_pkg::OP_OVER: begin
                new_depth <= depth + 1'b1; w0 <= c1; nwr <= 2'd1; state <= S_WR0;
              end
              sma_pkg::OP_ROT: begin
                w0 <= c1; w1 <= c2; w2 <= c0; nwr <= 2'd3; state <= S_WR0;
              end
              sma_pkg::OP_NROT: begin
                w0 <= c2; w1 <= c0; w2 <= c1; nwr <= 2'd3; state <= S_WR0;
              end
              sma_pkg::OP_NOT: begin
                w0 <= ~c0; nwr <= 2'd1; state <= S_WR0;
              end
              default: begin
                if (cmd >= sma_pkg::OP_ADD && cmd <= sma_pkg::OP_XOR) begin
                  alu_start <= 1'b1;
                  new_depth <= depth - 1'b1;
                  nwr <= 2'd1;
                  state <= S_WAIT;
                end
              end
            endcase
          end
        end
        S_WAIT: if (rsp.done) begin
          w0 <= alu_res;
          state <= S_WR0;
        end
        S_WR0: begin
          depth <= new_depth;
          if (nwr != 2'd0) top <= w0;
          // after a drop, fetch the new top
          if (nwr == 2'd0 && new_depth != '0) state <= S_TOP0;
          else if (nwr >= 2'd2) state <= S_WR1;
          else state <= S_OUT;
        end
        S_TOP0: state <= S_TOP1;
        S_TOP1: begin
          top <= rd_data;
          state <= S_OUT;
        end
        S_WR1: state <= (nwr == 2'd3) ? S_WR2 : S_OUT;
        S_WR2: state <= S_OUT;
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.top_value <= (depth == '0) ? '0 : sma_pkg::TOP_W'(top);
            out_ch.stack_count <= sma_pkg::CNT_W'(depth);
            out_ch.fault <= fault;
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
